@@ src/ucd_pkg.sv @@
// Package for the USB charger type detector.
// Holds codes, payload structs and constants shared by all src modules.
// No dependencies.
`default_nettype none

package ucd_pkg;

  localparam int CFG_WIDTH     = 12;
  localparam int CFG_IDX_WIDTH = 2;
  localparam int CUR_WIDTH     = 10;
  localparam int COUNT_WIDTH_DEF = 12;

  localparam logic [CFG_WIDTH-1:0] START_DELAY_RST    = 12'd100;
  localparam logic [CFG_WIDTH-1:0] PULLUP_TIMEOUT_RST = 12'd100;
  localparam logic [CFG_WIDTH-1:0] LINE_TIMEOUT_RST   = 12'd1000;

  localparam logic [CUR_WIDTH-1:0] CUR_1000MA = 10'd1000;
  localparam logic [CUR_WIDTH-1:0] CUR_500MA  = 10'd500;
  localparam logic [CUR_WIDTH-1:0] CUR_NONE   = 10'd0;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_START_DELAY    = 2'd0,
    CFG_PULLUP_TIMEOUT = 2'd1,
    CFG_LINE_TIMEOUT   = 2'd2
  } ucd_cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_POLL      = 2'd0,
    MODE_START     = 2'd1,
    MODE_CANCEL    = 2'd2,
    MODE_VBUS_LOST = 2'd3
  } ucd_mode_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DELAY  = 2'd1,
    PH_PULLUP = 2'd2,
    PH_LINES  = 2'd3
  } ucd_phase_t;

  typedef enum logic [2:0] {
    OC_NONE      = 3'd0,
    OC_NOVBUS    = 3'd1,
    OC_NOPULLUP  = 3'd2,
    OC_HOST      = 3'd3,
    OC_CHG1000   = 3'd4,
    OC_CHG500    = 3'd5,
    OC_UNCLASS   = 3'd6
  } ucd_outcome_t;

  typedef struct packed {
    ucd_mode_t mode;
    logic      vbus_present;
    logic      pullup_seen;
    logic      dplus_high;
    logic      dminus_high;
  } ucd_in_t;

  typedef struct packed {
    logic                 event_valid;
    logic                 event_source;
    logic [CUR_WIDTH-1:0] event_current_ma;
    ucd_phase_t           phase;
    ucd_outcome_t         outcome;
  } ucd_out_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] start_delay_ticks;
    logic [CFG_WIDTH-1:0] pullup_timeout_ticks;
    logic [CFG_WIDTH-1:0] line_timeout_ticks;
  } ucd_cfg_t;

endpackage

`default_nettype wire

@@ src/ucd_cfg_regs.sv @@
// Configuration register file for the charger type detector.
// Depends on ucd_pkg.
`default_nettype none

module ucd_cfg_regs
  import ucd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data,
  output ucd_cfg_t                      cfg
);

  ucd_cfg_t cfg_r;
  ucd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_DELAY:    cfg_nxt.start_delay_ticks    = cfg_data;
        CFG_PULLUP_TIMEOUT: cfg_nxt.pullup_timeout_ticks = cfg_data;
        CFG_LINE_TIMEOUT:   cfg_nxt.line_timeout_ticks   = cfg_data;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delay_ticks    <= START_DELAY_RST;
      cfg_r.pullup_timeout_ticks <= PULLUP_TIMEOUT_RST;
      cfg_r.line_timeout_ticks   <= LINE_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ src/ucd_fsm.sv @@
// Detection state machine: phase, tick counter and stored charger current.
// Computes one result per stepped transaction. Depends on ucd_pkg.
`default_nettype none

module ucd_fsm
  import ucd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire ucd_in_t  item,
  input  wire ucd_cfg_t cfg,
  output ucd_out_t      res
);

  localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam logic [CMP_WIDTH-1:0] CNT_MAX = CMP_WIDTH'({COUNT_WIDTH{1'b1}});

  ucd_phase_t             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [CUR_WIDTH-1:0]   cur_r, cur_nxt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   delay_hit, pullup_hit, line_hit;
  logic                   finished;

  function automatic logic limit_hit(input logic [COUNT_WIDTH-1:0] cnt,
                                     input logic [CFG_WIDTH-1:0]   lim);
    logic [CMP_WIDTH-1:0] lim_w;
    lim_w = CMP_WIDTH'(lim);
    if (lim_w > CNT_MAX) lim_w = CNT_MAX;
    return CMP_WIDTH'(cnt) >= lim_w;
  endfunction

  assign cnt_inc    = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r : cnt_r + 1'b1;
  assign delay_hit  = limit_hit(cnt_r, cfg.start_delay_ticks);
  assign pullup_hit = limit_hit(cnt_r, cfg.pullup_timeout_ticks);
  assign line_hit   = limit_hit(cnt_r, cfg.line_timeout_ticks);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    finished  = 1'b0;
    res       = '0;
    res.outcome = OC_NONE;
    unique case (item.mode)
      MODE_START: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_DELAY;
          cnt_nxt   = '0;
        end
      end
      MODE_CANCEL: begin
        if (phase_r == PH_DELAY) begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end
      end
      MODE_VBUS_LOST: begin
        if (cur_r != CUR_NONE) begin
          cur_nxt         = CUR_NONE;
          res.event_valid = 1'b1;
        end
      end
      default: begin
        unique case (phase_r)
          PH_DELAY: begin
            if (!delay_hit) begin
              cnt_nxt = cnt_inc;
            end else if (!item.vbus_present) begin
              phase_nxt       = PH_IDLE;
              cnt_nxt         = '0;
              res.event_valid = 1'b1;
              res.outcome     = OC_NOVBUS;
            end else begin
              phase_nxt = PH_PULLUP;
              cnt_nxt   = '0;
            end
          end
          PH_PULLUP: begin
            if (item.pullup_seen) begin
              phase_nxt = PH_LINES;
              cnt_nxt   = '0;
            end else if (pullup_hit) begin
              phase_nxt   = PH_IDLE;
              cnt_nxt     = '0;
              res.outcome = OC_NOPULLUP;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
          PH_LINES: begin
            if (item.dplus_high && item.dminus_high) begin
              cur_nxt     = CUR_1000MA;
              res.outcome = OC_CHG1000;
              finished    = 1'b1;
            end else if (!item.dplus_high && !item.dminus_high) begin
              res.outcome = OC_HOST;
              finished    = 1'b1;
            end else if (line_hit) begin
              if (item.dplus_high) begin
                cur_nxt     = CUR_500MA;
                res.outcome = OC_CHG500;
              end else begin
                res.outcome = OC_UNCLASS;
              end
              finished = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
            end
            if (finished) begin
              phase_nxt = PH_IDLE;
              cnt_nxt   = '0;
              if (cur_nxt != CUR_NONE) begin
                res.event_valid      = 1'b1;
                res.event_source     = 1'b1;
                res.event_current_ma = cur_nxt;
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    endcase
    res.phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      cur_r   <= CUR_NONE;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/usb_charger_type_detector.sv @@
// USB charger type detector, top level.
// Input register, detection state machine and result register.
// Depends on ucd_pkg, ucd_cfg_regs and ucd_fsm.
//
// Usage: each input transaction is a poll tick, start, cancel or VBUS-lost
// request with sampled VBUS, pull-up and D+/D- levels. Every input
// transaction yields exactly one result transaction carrying the event
// flag, source, current, the phase after the step and the outcome of a
// detection that ended on it.
// Pipeline: a transaction is captured in the input register, stepped through the
// state machine once the result register can take it, and its result is held there.
// Throughput: one transaction per cycle while out_stall does not hold the result;
// the state machine updates its state on every accepted transaction.
// Reset (rst_n low, synchronous): phase idle, counter and stored current
// zero, both channels empty, timeouts back to 100/100/1000 ticks.
// Stall: when out_stall holds the result, the input register still takes
// one more transaction, then in_stall rises until the result is taken.
// Configuration writes take effect on the next edge; write only while idle.
`default_nettype none

module usb_charger_type_detector
  import ucd_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire ucd_in_t                  in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output ucd_out_t                      out_data,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

  ucd_cfg_t cfg;
  ucd_out_t res;
  ucd_in_t  in_data_r;
  ucd_out_t out_data_r;
  logic     in_valid_r;
  logic     out_valid_r;
  logic     fire;

  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;

  ucd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ucd_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (in_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ tb/usb_charger_type_detector_tb.sv @@
// Testbench for usb_charger_type_detector: a directed table, then random detection runs.
// Results are checked against table values or an in-bench detection predictor under random valid/stall gaps.
// Depends on ucd_pkg and the usb_charger_type_detector RTL.
`default_nettype none

module usb_charger_type_detector_tb;
  import ucd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  ucd_in_t                  in_data;
  logic                     out_valid;
  logic                     out_stall;
  ucd_out_t                 out_data;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]     cfg_data;

  usb_charger_type_detector uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    ucd_in_t  stim;
    bit       typed;
    ucd_out_t want;
  } dir_row_t;

  // predicted detector state and register copies
  ucd_phase_t           pred_phase;
  logic [11:0]          pred_ticks;
  logic [CUR_WIDTH-1:0] pred_current;
  logic [CFG_WIDTH-1:0] cfg_delay;
  logic [CFG_WIDTH-1:0] cfg_pullup_to;
  logic [CFG_WIDTH-1:0] cfg_line_to;

  ucd_out_t expected_results[$];
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       sent_items = 0;
  bit       tx_quiet = 0;
  bit       rx_quiet = 0;
  bit       hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Limits never exceed the counter maximum, so the count cannot saturate.
  function automatic ucd_out_t detect_step(ucd_in_t it);
    ucd_out_t r;
    logic     done;
    r = '0;
    done = 1'b0;
    case (it.mode)
      MODE_START: if (pred_phase == PH_IDLE) begin
        pred_phase = PH_DELAY;
        pred_ticks = '0;
      end
      MODE_CANCEL: if (pred_phase == PH_DELAY) begin
        pred_phase = PH_IDLE;
        pred_ticks = '0;
      end
      MODE_VBUS_LOST: if (pred_current != CUR_NONE) begin
        pred_current = CUR_NONE;
        r.event_valid = 1'b1;
      end
      default: begin
        case (pred_phase)
          PH_DELAY: begin
            if (pred_ticks < cfg_delay) begin
              pred_ticks = pred_ticks + 1'b1;
            end else if (!it.vbus_present) begin
              pred_phase = PH_IDLE;
              pred_ticks = '0;
              r.event_valid = 1'b1;
              r.outcome = OC_NOVBUS;
            end else begin
              pred_phase = PH_PULLUP;
              pred_ticks = '0;
            end
          end
          PH_PULLUP: begin
            if (it.pullup_seen) begin
              pred_phase = PH_LINES;
              pred_ticks = '0;
            end else if (pred_ticks >= cfg_pullup_to) begin
              pred_phase = PH_IDLE;
              pred_ticks = '0;
              r.outcome = OC_NOPULLUP;
            end else begin
              pred_ticks = pred_ticks + 1'b1;
            end
          end
          PH_LINES: begin
            if (it.dplus_high && it.dminus_high) begin
              pred_current = CUR_1000MA;
              r.outcome = OC_CHG1000;
              done = 1'b1;
            end else if (!it.dplus_high && !it.dminus_high) begin
              r.outcome = OC_HOST;
              done = 1'b1;
            end else if (pred_ticks >= cfg_line_to) begin
              if (it.dplus_high) begin
                pred_current = CUR_500MA;
                r.outcome = OC_CHG500;
              end else begin
                r.outcome = OC_UNCLASS;
              end
              done = 1'b1;
            end else begin
              pred_ticks = pred_ticks + 1'b1;
            end
            if (done) begin
              pred_phase = PH_IDLE;
              pred_ticks = '0;
              if (pred_current != CUR_NONE) begin
                r.event_valid = 1'b1;
                r.event_source = 1'b1;
                r.event_current_ma = pred_current;
              end
            end
          end
          default: ;
        endcase
      end
    endcase
    r.phase = pred_phase;
    return r;
  endfunction

  function automatic ucd_out_t res(logic ev, logic src, logic [CUR_WIDTH-1:0] cur,
                                   ucd_phase_t ph, ucd_outcome_t oc);
    ucd_out_t r;
    r.event_valid = ev;
    r.event_source = src;
    r.event_current_ma = cur;
    r.phase = ph;
    r.outcome = oc;
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic add_row(ucd_mode_t m, logic [3:0] lines, bit typed, ucd_out_t want);
    dir_row_t r;
    r.stim = {m, lines};
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  task automatic tx_gap(int n);
    if (n > 0 && !tx_quiet) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(ucd_in_t it, bit typed, ucd_out_t want);
    ucd_out_t pred;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = detect_step(it);
    expected_results.push_back(typed ? want : pred);
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(logic [CFG_WIDTH-1:0] d, logic [CFG_WIDTH-1:0] p,
                             logic [CFG_WIDTH-1:0] l);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_START_DELAY;
    cfg_data <= d;
    @(posedge clk);
    cfg_delay = d;
    cfg_index <= CFG_PULLUP_TIMEOUT;
    cfg_data <= p;
    @(posedge clk);
    cfg_pullup_to = p;
    cfg_index <= CFG_LINE_TIMEOUT;
    cfg_data <= l;
    @(posedge clk);
    cfg_line_to = l;
    cfg_we <= 1'b0;
  endtask

  // start, then poll ticks (with occasional stray requests) until back to idle
  task automatic run_detection(int vbus_pct, int pull_pct, int settle_pct, int noise_pct);
    ucd_in_t it;
    tx_gap(idle_len());
    send_item({MODE_START, 4'($urandom_range(0, 15))}, 1'b0, '0);
    while (pred_phase != PH_IDLE) begin
      tx_gap(idle_len());
      if ($urandom_range(0, 99) < noise_pct) begin
        it = ucd_in_t'($urandom_range(0, 63));
      end else begin
        it.mode = MODE_POLL;
        it.vbus_present = ($urandom_range(0, 99) < vbus_pct);
        it.pullup_seen = ($urandom_range(0, 99) < pull_pct);
        it.dplus_high = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < settle_pct) begin
          it.dminus_high = it.dplus_high;
        end else begin
          it.dminus_high = !it.dplus_high;
        end
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic random_phase(int n_items, int pressure);
    int first;
    first = sent_items;
    while (sent_items - first < n_items) begin
      tx_quiet = ($urandom_range(0, 9) == 0);
      rx_quiet = tx_quiet;
      if (pressure == 1 && sent_items - first > n_items / 3) begin
        hold_req = 1'b1;
        pressure = 0;
      end
      if (pressure == 2 && sent_items - first > n_items / 2) begin
        wait_drained();
        pressure = 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          tx_gap(idle_len());
          send_item(ucd_in_t'($urandom_range(0, 63)), 1'b0, '0);
        end
      end
      run_detection($urandom_range(70, 100), $urandom_range(20, 90),
                    $urandom_range(20, 80), $urandom_range(0, 8));
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // result side: random stall bursts, one long hold on request, field checks
  initial begin
    int stall_left;
    int hold_left;
    ucd_out_t exp_r;
    stall_left = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with none pending: %p", out_data);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.event_valid !== exp_r.event_valid) begin
            $error("event_valid: expected %0d, got %0d", exp_r.event_valid,
                   out_data.event_valid);
            mismatches++;
          end
          if (out_data.event_source !== exp_r.event_source) begin
            $error("event_source: expected %0d, got %0d", exp_r.event_source,
                   out_data.event_source);
            mismatches++;
          end
          if (out_data.event_current_ma !== exp_r.event_current_ma) begin
            $error("event_current_ma: expected %0d, got %0d", exp_r.event_current_ma,
                   out_data.event_current_ma);
            mismatches++;
          end
          if (out_data.phase !== exp_r.phase) begin
            $error("phase: expected %0d, got %0d", exp_r.phase, out_data.phase);
            mismatches++;
          end
          if (out_data.outcome !== exp_r.outcome) begin
            $error("outcome: expected %0d, got %0d", exp_r.outcome, out_data.outcome);
            mismatches++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = rx_quiet ? 0 : idle_len();
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_START_DELAY;
    cfg_data <= '0;
    pred_phase = PH_IDLE;
    pred_ticks = '0;
    pred_current = CUR_NONE;
    cfg_delay = START_DELAY_RST;
    cfg_pullup_to = PULLUP_TIMEOUT_RST;
    cfg_line_to = LINE_TIMEOUT_RST;

    // lines field: {vbus, pullup, D+, D-}
    add_row(MODE_POLL,      4'b1111, 1'b1, res(1'b0, 1'b0, CUR_NONE, PH_IDLE, OC_NONE));
    add_row(MODE_VBUS_LOST, 4'b0000, 1'b1, res(1'b0, 1'b0, CUR_NONE, PH_IDLE, OC_NONE));
    add_row(MODE_START,     4'b0101, 1'b1, res(1'b0, 1'b0, CUR_NONE, PH_DELAY, OC_NONE));
    add_row(MODE_START,     4'b1111, 1'b0, '0);
    add_row(MODE_CANCEL,    4'b0000, 1'b1, res(1'b0, 1'b0, CUR_NONE, PH_IDLE, OC_NONE));
    add_row(MODE_START,     4'b0000, 1'b0, '0);
    add_row(MODE_POLL,      4'b0111, 1'b1, res(1'b1, 1'b0, CUR_NONE, PH_IDLE, OC_NOVBUS));
    add_row(MODE_START,     4'b1000, 1'b0, '0);
    add_row(MODE_POLL,      4'b1000, 1'b0, '0);
    add_row(MODE_CANCEL,    4'b1111, 1'b0, '0);
    add_row(MODE_POLL,      4'b1011, 1'b1, res(1'b0, 1'b0, CUR_NONE, PH_IDLE, OC_NOPULLUP));
    add_row(MODE_START,     4'b0000, 1'b0, '0);
    add_row(MODE_POLL,      4'b1000, 1'b0, '0);
    add_row(MODE_POLL,      4'b0100, 1'b0, '0);
    add_row(MODE_POLL,      4'b1100, 1'b1, res(1'b0, 1'b0, CUR_NONE, PH_IDLE, OC_HOST));
    add_row(MODE_START,     4'b0000, 1'b0, '0);
    add_row(MODE_POLL,      4'b1000, 1'b0, '0);
    add_row(MODE_POLL,      4'b1100, 1'b0, '0);
    add_row(MODE_POLL,      4'b0110, 1'b1, res(1'b1, 1'b1, CUR_500MA, PH_IDLE, OC_CHG500));
    add_row(MODE_START,     4'b0000, 1'b0, '0);
    add_row(MODE_POLL,      4'b1000, 1'b0, '0);
    add_row(MODE_POLL,      4'b0100, 1'b0, '0);
    add_row(MODE_POLL,      4'b1101, 1'b0, '0);
    add_row(MODE_VBUS_LOST, 4'b1111, 1'b1, res(1'b1, 1'b0, CUR_NONE, PH_IDLE, OC_NONE));
    add_row(MODE_START,     4'b0000, 1'b0, '0);
    add_row(MODE_POLL,      4'b1000, 1'b0, '0);
    add_row(MODE_POLL,      4'b0100, 1'b0, '0);
    add_row(MODE_POLL,      4'b0011, 1'b1, res(1'b1, 1'b1, CUR_1000MA, PH_IDLE, OC_CHG1000));
    add_row(MODE_START,     4'b0000, 1'b0, '0);
    add_row(MODE_POLL,      4'b1000, 1'b0, '0);
    add_row(MODE_POLL,      4'b0100, 1'b0, '0);
    add_row(MODE_POLL,      4'b0000, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    load_config('0, '0, '0);
    foreach (dir_rows[i]) begin
      tx_gap(idle_len());
      send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    load_config(12'($urandom_range(0, 3)), 12'($urandom_range(0, 3)),
                12'($urandom_range(0, 3)));
    random_phase(150, 0);
    load_config(12'd1, 12'd5, 12'd8);
    random_phase(150, 1);
    load_config(12'($urandom_range(0, 10)), 12'($urandom_range(0, 10)),
                12'($urandom_range(0, 10)));
    random_phase(150, 2);
    load_config('0, '0, '0);
    random_phase(120, 0);

    load_config(12'($urandom_range(0, 40)), 12'($urandom_range(0, 30)),
                12'($urandom_range(0, 30)));
    random_phase(120, 0);

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
